// File: sv/p2c_pkg.sv
// p2c_pkg: shared widths, register indexes, CORDIC angle table and stage types
// for the polar sample coordinate pipeline. No dependencies.
`default_nettype none

package p2c_pkg;

  // Input and configuration port geometry.
  localparam int ROW_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CART_STEP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BIN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RANGE_BIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_AZIMUTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_AZIMUTH_STEP = 3'd5;

  // Modulo by grid size uses a reciprocal with this many fraction bits.
  localparam int MOD_SHIFT = 22;

  // Datapath widths.
  localparam int XY_W       = 32;  // clamped metric coordinates, signed
  localparam int SQ_W       = 64;  // square-root remainder and root working width
  localparam int ROOT_W     = 32;  // final integer square root
  localparam int SQRT_STEPS = 32;  // one result bit per stage
  localparam int CW         = 35;  // CORDIC vector width, signed
  localparam int ZW         = 34;  // CORDIC angle accumulator, signed Q.30
  localparam int CORDIC_MAX = 24;  // entries in the arctangent table
  localparam int OUT_W      = 28;

  localparam logic signed [XY_W-1:0] XY_MAX = 32'sd2147483647;
  localparam logic signed [ZW-1:0]   PI_Q30 = 34'sd3373259426;
  localparam logic signed [ZW:0]     TWO_PI_Q30 = 35'sd6746518852;

  localparam logic [OUT_W-1:0] U_MAX = 28'hFFFFFFF;
  localparam logic signed [OUT_W-1:0] V_MAX = 28'sh7FFFFFF;
  localparam logic signed [OUT_W-1:0] V_MIN = -28'sh8000000;

  // Configuration register set, seen by the front and back stages.
  typedef struct packed {
    logic [23:0] half_extent;
    logic [23:0] cart_step;
    logic [15:0] half_bin;
    logic [23:0] inv_range_bin;
    logic [18:0] first_azimuth;
    logic [23:0] inv_azimuth_step;
  } p2c_cfg_t;

  // State carried through the square-root and CORDIC stages.
  typedef struct packed {
    logic [SQ_W-1:0]       rem;
    logic [SQ_W-1:0]       root;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic signed [ZW-1:0]  z;
  } p2c_iter_t;

  typedef struct packed {
    logic [OUT_W-1:0]        u;
    logic signed [OUT_W-1:0] v;
  } p2c_sample_t;

  // atan(2^-i) in Q.30 radians.
  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] a;
    a = '0;
    unique case (i)
      0:  a = 31'd843314857;
      1:  a = 31'd497837829;
      2:  a = 31'd263043837;
      3:  a = 31'd133525159;
      4:  a = 31'd67021687;
      5:  a = 31'd33543516;
      6:  a = 31'd16775851;
      7:  a = 31'd8388437;
      8:  a = 31'd4194283;
      9:  a = 31'd2097149;
      10: a = 31'd1048576;
      11: a = 31'd524288;
      12: a = 31'd262144;
      13: a = 31'd131072;
      14: a = 31'd65536;
      15: a = 31'd32768;
      16: a = 31'd16384;
      17: a = 31'd8192;
      18: a = 31'd4096;
      19: a = 31'd2048;
      20: a = 31'd1024;
      21: a = 31'd512;
      22: a = 31'd256;
      23: a = 31'd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: sv/p2c_front.sv
// p2c_front: grid wrap, metric coordinates, clamping, squaring and CORDIC setup.
// Six register stages. Depends on p2c_pkg.
`default_nettype none

module p2c_front import p2c_pkg::*; #(
  parameter int GRID_SIZE = 512
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [ROW_W-1:0]  row,
  input  wire logic [ROW_W-1:0]  col,
  input  wire p2c_cfg_t          cfg,
  output logic                   out_valid,
  output p2c_iter_t              out_data
);

  localparam int GW = $clog2(GRID_SIZE + 1);
  localparam int MW = ROW_W + MOD_SHIFT;
  localparam int QW = ROW_W + GW;
  localparam int PW = ROW_W + 24;
  localparam int DW = PW + 2;
  localparam int SQH_W = 2 * (XY_W - 1);
  localparam logic [MOD_SHIFT-1:0] MOD_MUL = MOD_SHIFT'((1 << MOD_SHIFT) / GRID_SIZE);
  localparam logic [GW-1:0] GRID_VAL = GW'(GRID_SIZE);

  function automatic logic signed [XY_W-1:0] sat_xy(input logic signed [DW-1:0] d);
    logic signed [DW-1:0] hi;
    hi = {{(DW-XY_W){1'b0}}, XY_MAX};
    if (d > hi) begin
      return XY_MAX;
    end else if (d < -hi) begin
      return -XY_MAX;
    end
    return d[XY_W-1:0];
  endfunction

  // Stage A: quotient estimate by reciprocal.
  logic             a_valid;
  logic [ROW_W-1:0] a_row, a_col, a_qr, a_qc;
  logic [MW-1:0]    mr, mc;

  assign mr = MW'(row) * MW'(MOD_MUL);
  assign mc = MW'(col) * MW'(MOD_MUL);

  // Stage B: remainder with a single correction step.
  logic             b_valid;
  logic [ROW_W-1:0] b_row, b_col;
  logic [QW-1:0]    dr, dc, rr, rc;

  always_comb begin
    dr = QW'(a_row) - QW'(a_qr) * QW'(GRID_VAL);
    dc = QW'(a_col) - QW'(a_qc) * QW'(GRID_VAL);
    rr = (dr >= QW'(GRID_VAL)) ? dr - QW'(GRID_VAL) : dr;
    rc = (dc >= QW'(GRID_VAL)) ? dc - QW'(GRID_VAL) : dc;
  end

  // Stage C: scale by pixel size.
  logic          c_valid;
  logic [PW-1:0] c_pr, c_pc;

  // Stage D: metric coordinates, clamped.
  logic                   d_valid;
  logic signed [XY_W-1:0] d_x, d_y;
  logic signed [DW-1:0]   xd, yd;

  assign xd = $signed(DW'(cfg.half_extent)) - $signed(DW'(c_pr));
  assign yd = $signed(DW'(c_pc)) - $signed(DW'(cfg.half_extent));

  // Stage E: squares, and the vector moved into the right half plane.
  logic                  e_valid;
  logic [SQH_W-1:0]      e_xx, e_yy;
  logic signed [CW-1:0]  e_cx, e_cy;
  logic signed [ZW-1:0]  e_z;
  logic [XY_W-2:0]       ax, ay;
  logic signed [CW-1:0]  sx, sy;

  always_comb begin
    ax = d_x[XY_W-1] ? ((XY_W-1)'(-d_x)) : d_x[XY_W-2:0];
    ay = d_y[XY_W-1] ? ((XY_W-1)'(-d_y)) : d_y[XY_W-2:0];
    sx = {{(CW-XY_W){d_x[XY_W-1]}}, d_x};
    sy = {{(CW-XY_W){d_y[XY_W-1]}}, d_y};
  end

  // Stage F: sum of squares.
  logic      f_valid;
  p2c_iter_t f_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_row <= row;
      a_col <= col;
      a_qr  <= mr[MW-1:MOD_SHIFT];
      a_qc  <= mc[MW-1:MOD_SHIFT];

      b_row <= rr[ROW_W-1:0];
      b_col <= rc[ROW_W-1:0];

      c_pr <= PW'(b_row) * PW'(cfg.cart_step);
      c_pc <= PW'(b_col) * PW'(cfg.cart_step);

      d_x <= sat_xy(xd);
      d_y <= sat_xy(yd);

      e_xx <= SQH_W'(ax) * SQH_W'(ax);
      e_yy <= SQH_W'(ay) * SQH_W'(ay);
      if (d_x[XY_W-1]) begin
        e_cx <= -sx;
        e_cy <= -sy;
        e_z  <= PI_Q30;
      end else begin
        e_cx <= sx;
        e_cy <= sy;
        e_z  <= '0;
      end

      f_data.rem  <= SQ_W'(e_xx) + SQ_W'(e_yy);
      f_data.root <= '0;
      f_data.cx   <= e_cx;
      f_data.cy   <= e_cy;
      f_data.z    <= e_z;
    end
  end

  assign out_valid = f_valid;
  assign out_data  = f_data;

endmodule

`default_nettype wire

// File: sv/p2c_iter_stage.sv
// p2c_iter_stage: one register stage of the bit-serial square root and, for the
// first CORDIC_STAGES stages (at most CORDIC_MAX), one vectoring CORDIC rotation. Depends on p2c_pkg.
`default_nettype none

module p2c_iter_stage import p2c_pkg::*; #(
  parameter int K             = 0,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire p2c_iter_t in_data,
  output logic       out_valid,
  output p2c_iter_t  out_data
);

  localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - K));
  localparam bit DO_ROT = (K < CORDIC_STAGES) && (K < CORDIC_MAX);
  localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(atan_q30(K)));

  logic [SQ_W-1:0]      trial;
  logic signed [CW-1:0] cx, cy, dx, dy;
  p2c_iter_t            nxt;

  always_comb begin
    cx    = in_data.cx;
    cy    = in_data.cy;
    dx    = cy >>> K;
    dy    = cx >>> K;
    trial = in_data.root + SQ_BIT;
    nxt   = in_data;

    if (in_data.rem >= trial) begin
      nxt.rem  = in_data.rem - trial;
      nxt.root = (in_data.root >> 1) + SQ_BIT;
    end else begin
      nxt.root = in_data.root >> 1;
    end

    // A vector already on the axis is left where it is.
    priority if (DO_ROT && cy > 0) begin
      nxt.cx = cx + dx;
      nxt.cy = cy - dy;
      nxt.z  = in_data.z + ATAN;
    end else if (DO_ROT && cy < 0) begin
      nxt.cx = cx - dx;
      nxt.cy = cy + dy;
      nxt.z  = in_data.z - ATAN;
    end else begin
      nxt.cx = cx;
      nxt.cy = cy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/p2c_back.sv
// p2c_back: angle wrap, offset removal, scaling by the reciprocal registers,
// rounding and saturation. Three register stages. Depends on p2c_pkg.
`default_nettype none

module p2c_back import p2c_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire p2c_iter_t in_data,
  input  wire p2c_cfg_t  cfg,
  output logic           out_valid,
  output p2c_sample_t    out_data
);

  localparam int DU_W = ROOT_W + 2;
  localparam int DV_W = ZW + 1;
  localparam int PU_W = DU_W + 25;
  localparam int PV_W = DV_W + 25;
  localparam logic signed [PU_W-1:0] U_RND = PU_W'(1) << 15;
  localparam logic signed [PV_W-1:0] V_RND = PV_W'(1) << 29;
  localparam logic signed [PU_W-1:0] U_HI  = $signed(PU_W'(U_MAX));
  localparam logic signed [PV_W-1:0] V_HI  = PV_W'(V_MAX);
  localparam logic signed [PV_W-1:0] V_LO  = PV_W'(V_MIN);

  // Stage W: wrap the angle into one turn and subtract the offsets.
  logic signed [DV_W-1:0] zx, zw, dv;
  logic signed [DU_W-1:0] du;

  always_comb begin
    zx = {in_data.z[ZW-1], in_data.z};
    if (zx < 0) begin
      zw = zx + TWO_PI_Q30;
    end else if (zx >= TWO_PI_Q30) begin
      zw = zx - TWO_PI_Q30;
    end else begin
      zw = zx;
    end
    dv = zw - $signed({2'b00, cfg.first_azimuth, 14'b0});
    du = $signed({2'b00, in_data.root[ROOT_W-1:0]}) -
         $signed({{(DU_W-16){1'b0}}, cfg.half_bin});
  end

  logic                   w_valid;
  logic signed [DU_W-1:0] w_du;
  logic signed [DV_W-1:0] w_dv;

  // Stage M: products.
  logic                   m_valid;
  logic signed [PU_W-1:0] m_pu;
  logic signed [PV_W-1:0] m_pv;

  // Stage R: round half up, then saturate.
  logic signed [PU_W-1:0] ru;
  logic signed [PV_W-1:0] rv;
  logic [OUT_W-1:0]        su;
  logic signed [OUT_W-1:0] sv;

  always_comb begin
    ru = (m_pu + U_RND) >>> 16;
    rv = (m_pv + V_RND) >>> 30;
    if (ru < 0) begin
      su = '0;
    end else if (ru > U_HI) begin
      su = U_MAX;
    end else begin
      su = ru[OUT_W-1:0];
    end
    if (rv > V_HI) begin
      sv = V_MAX;
    end else if (rv < V_LO) begin
      sv = V_MIN;
    end else begin
      sv = rv[OUT_W-1:0];
    end
  end

  logic        r_valid;
  p2c_sample_t r_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
      m_valid <= 1'b0;
      r_valid <= 1'b0;
    end else if (en) begin
      w_valid <= in_valid;
      m_valid <= w_valid;
      r_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_du     <= du;
      w_dv     <= dv;
      m_pu     <= w_du * $signed({1'b0, cfg.inv_range_bin});
      m_pv     <= w_dv * $signed({1'b0, cfg.inv_azimuth_step});
      r_data.u <= su;
      r_data.v <= sv;
    end
  end

  assign out_valid = r_valid;
  assign out_data  = r_data;

endmodule

`default_nettype wire

// File: sv/p2c_out_buf.sv
// p2c_out_buf: output register with a one-entry skid stage; produces the
// pipeline advance enable. Depends on p2c_pkg.
`default_nettype none

module p2c_out_buf import p2c_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire p2c_sample_t in_data,
  input  wire logic        out_stall,
  output logic             out_valid,
  output p2c_sample_t      out_data,
  output logic             en
);

  logic        skid_valid;
  p2c_sample_t skid_data;
  logic        moving;

  // The pipeline freezes as soon as the skid entry holds a result.
  assign en     = !skid_valid;
  assign moving = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= moving;
        out_data  <= in_data;
      end
    end else if (moving) begin
      skid_valid <= 1'b1;
      skid_data  <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/polar_to_cartesian_sample_coords.sv
// Top level of the polar sample coordinate generator: configuration registers,
// front end, square-root/CORDIC stage chain, back end and output buffer.
// Depends on p2c_pkg, p2c_front, p2c_iter_stage, p2c_back and p2c_out_buf.
//
// Usage. Each input transaction on the coord channel (row, col) names one
// Cartesian output pixel; the block returns one sample channel transaction
// carrying range_idx, the fractional range-bin index (unsigned Q12.16), and
// azimuth_idx, the fractional azimuth index (signed Q11.16). A transaction is
// taken at a rising edge where valid is high and stall is low.
// Throughput is one pixel per clock while the receiver does not stall. From the
// input transaction to sample_valid a pixel passes six front stages (grid wrap,
// scaling, clamp, squares), 32 stages that each produce one square-root bit and,
// in the first CORDIC_STAGES of them, one CORDIC rotation, three back stages
// (angle wrap, reciprocal multiply, round and saturate) and the output register.
// The six configuration registers are written through the cfg channel, which
// is always ready; indexes past the last register are ignored. Writes are
// meant to happen only while no pixel is in flight.
// Reset clears all valid bits and restores the register defaults.
// When the receiver stalls, the output register holds its transaction and one
// more result lands in a skid entry; the whole pipeline then freezes and
// coord_stall rises in the same cycle, so nothing is dropped or repeated.
`default_nettype none

module polar_to_cartesian_sample_coords import p2c_pkg::*; #(
  parameter int GRID_SIZE     = 512,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   coord_valid,
  output logic                        coord_stall,
  input  wire logic [ROW_W-1:0]       row,
  input  wire logic [ROW_W-1:0]       col,
  output logic                        sample_valid,
  input  wire logic                   sample_stall,
  output logic [OUT_W-1:0]            range_idx,
  output logic signed [OUT_W-1:0]     azimuth_idx,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  p2c_cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_extent      <= 24'd3276800;
      cfg.cart_step        <= 24'd16384;
      cfg.half_bin         <= 16'd1416;
      cfg.inv_range_bin    <= 24'd1517037;
      cfg.first_azimuth    <= 19'd0;
      cfg.inv_azimuth_step <= 24'd4172151;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HALF_EXTENT:      cfg.half_extent      <= cfg_data;
        REG_CART_STEP:        cfg.cart_step        <= cfg_data;
        REG_HALF_BIN:         cfg.half_bin         <= cfg_data[15:0];
        REG_INV_RANGE_BIN:    cfg.inv_range_bin    <= cfg_data;
        REG_FIRST_AZIMUTH:    cfg.first_azimuth    <= cfg_data[18:0];
        REG_INV_AZIMUTH_STEP: cfg.inv_azimuth_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves together unless the skid entry is full.
  logic en;

  assign coord_stall = !en;

  logic      chain_valid [SQRT_STEPS+1];
  p2c_iter_t chain_data  [SQRT_STEPS+1];

  p2c_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (coord_valid),
    .row       (row),
    .col       (col),
    .cfg       (cfg),
    .out_valid (chain_valid[0]),
    .out_data  (chain_data[0])
  );

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_iter
    p2c_iter_stage #(
      .K             (k),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[k]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  logic        back_valid;
  p2c_sample_t back_data;

  p2c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_valid[SQRT_STEPS]),
    .in_data   (chain_data[SQRT_STEPS]),
    .cfg       (cfg),
    .out_valid (back_valid),
    .out_data  (back_data)
  );

  p2c_sample_t sample_data;

  p2c_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (back_valid),
    .in_data   (back_data),
    .out_stall (sample_stall),
    .out_valid (sample_valid),
    .out_data  (sample_data),
    .en        (en)
  );

  assign range_idx   = sample_data.u;
  assign azimuth_idx = sample_data.v;

endmodule

`default_nettype wire

// File: verif/polar_to_cartesian_sample_coords_tb.sv
// Self-checking testbench for polar_to_cartesian_sample_coords: drives pixel
// coordinates and register writes, and checks every sample against a predictor or a typed-in value.
// Depends on p2c_pkg and the polar_to_cartesian_sample_coords RTL.
`timescale 1ns / 1ps

module polar_to_cartesian_sample_coords_tb;
  import p2c_pkg::*;

  localparam int GRID          = 512;
  localparam int CORDIC_STAGES = 16;

  // Predictor constants, held as 64-bit signed values so that no comparison
  // silently turns unsigned.
  localparam longint XY_TOP    = 64'sd2147483647;
  localparam longint HALF_TURN = 64'sd3373259426;
  localparam longint FULL_TURN = 64'sd6746518852;
  localparam longint U_TOP     = 64'sd268435455;
  localparam longint V_TOP     = 64'sd134217727;
  localparam longint V_BOT     = -64'sd134217728;
  localparam longint ROUND_U   = 64'sd32768;
  localparam longint ROUND_V   = 64'sd536870912;

  // The two register indexes past the end of the list; writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] NO_REG_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] NO_REG_HI = 3'd7;

  // atan(2^-i) in Q.30 radians, one entry per possible rotation.
  localparam longint ATAN_Q30 [0:23] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

  // One directed pixel. When fixed is set, the expected sample is typed in
  // below; otherwise it comes from the predictor.
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic                    fixed;
    logic [OUT_W-1:0]        u;
    logic signed [OUT_W-1:0] v;
  } pixel_case_t;

  localparam int N_DIRECTED = 17;

  // With the reset registers the grid is 512 pixels of 0.25 m around a
  // 50 m half width, so pixel (200, 200) sits on the origin.
  pixel_case_t directed_pixels [0:N_DIRECTED-1] = '{
    '{9'd200, 9'd200, 1'b1, 28'd0, 28'sd0},  // origin: range and angle are zero
    '{9'd0,   9'd200, 1'b0, 28'd0, 28'sd0},  // positive x axis, angle exactly zero
    '{9'd511, 9'd200, 1'b0, 28'd0, 28'sd0},  // negative x axis, angle pi
    '{9'd200, 9'd0,   1'b0, 28'd0, 28'sd0},  // negative y axis, wraps past zero
    '{9'd200, 9'd511, 1'b0, 28'd0, 28'sd0},  // positive y axis
    '{9'd0,   9'd0,   1'b0, 28'd0, 28'sd0},
    '{9'd0,   9'd511, 1'b0, 28'd0, 28'sd0},
    '{9'd511, 9'd0,   1'b0, 28'd0, 28'sd0},
    '{9'd511, 9'd511, 1'b0, 28'd0, 28'sd0},
    '{9'd199, 9'd200, 1'b0, 28'd0, 28'sd0},
    '{9'd201, 9'd200, 1'b0, 28'd0, 28'sd0},
    '{9'd200, 9'd199, 1'b0, 28'd0, 28'sd0},
    '{9'd200, 9'd201, 1'b0, 28'd0, 28'sd0},
    '{9'h155, 9'h0AA, 1'b0, 28'd0, 28'sd0},
    '{9'h0AA, 9'h155, 1'b0, 28'd0, 28'sd0},
    '{9'd100, 9'd300, 1'b0, 28'd0, 28'sd0},
    '{9'd300, 9'd100, 1'b0, 28'd0, 28'sd0}
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    coord_valid = 1'b0;
  logic                    coord_stall;
  logic [ROW_W-1:0]        row = '0;
  logic [ROW_W-1:0]        col = '0;
  logic                    sample_valid;
  logic                    sample_stall = 1'b0;
  logic [OUT_W-1:0]        range_idx;
  logic signed [OUT_W-1:0] azimuth_idx;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Register values the predictor works from; they follow every accepted write.
  p2c_cfg_t    live_regs;
  p2c_sample_t pending_samples [$];
  p2c_sample_t oldest_sample;
  int          mismatches = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  polar_to_cartesian_sample_coords #(
    .GRID_SIZE    (GRID),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .row         (row),
    .col         (col),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .range_idx   (range_idx),
    .azimuth_idx (azimuth_idx),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // Works out the sample for one pixel: metric position, exact integer square
  // root for the range, a vectoring CORDIC for the angle, then the reciprocal
  // multiplies with rounding and saturation.
  function automatic p2c_sample_t predict_sample(input p2c_cfg_t c,
                                                 input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] q);
    longint rr, qq, he, step, px, py, rng, u, v, z, off, dx, dy;
    longint unsigned sq, root, probe;
    int i;
    p2c_sample_t s;
    rr = 64'(r);
    qq = 64'(q);
    rr = rr % GRID;
    qq = qq % GRID;
    he = 64'(c.half_extent);
    step = 64'(c.cart_step);
    px = he - rr * step;
    py = qq * step - he;
    if (px > XY_TOP) px = XY_TOP;
    if (px < -XY_TOP) px = -XY_TOP;
    if (py > XY_TOP) py = XY_TOP;
    if (py < -XY_TOP) py = -XY_TOP;

    sq = px * px + py * py;
    root = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > sq) probe = probe >> 2;
    while (probe != 0) begin
      if (sq >= root + probe) begin
        sq = sq - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    rng = root;

    u = 64'(c.half_bin);
    u = rng - u;
    rr = 64'(c.inv_range_bin);
    u = u * rr;
    u = (u + ROUND_U) >>> 16;
    if (u < 0) u = 0;
    if (u > U_TOP) u = U_TOP;

    // The origin has no direction and is given angle zero. A vector in the
    // left half plane is turned around first and pi is added back afterwards.
    z = 0;
    off = 0;
    if (px != 0 || py != 0) begin
      if (px < 0) begin
        px = -px;
        py = -py;
        off = HALF_TURN;
      end
      for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        dx = py >>> i;
        dy = px >>> i;
        if (py > 0) begin
          px = px + dx;
          py = py - dy;
          z = z + ATAN_Q30[i];
        end else if (py < 0) begin
          px = px - dx;
          py = py + dy;
          z = z - ATAN_Q30[i];
        end
      end
      z = z + off;
      if (z < 0) z = z + FULL_TURN;
      if (z >= FULL_TURN) z = z - FULL_TURN;
    end

    v = 64'(c.first_azimuth);
    v = z - (v << 14);
    qq = 64'(c.inv_azimuth_step);
    v = v * qq;
    v = (v + ROUND_V) >>> 30;
    if (v > V_TOP) v = V_TOP;
    if (v < V_BOT) v = V_BOT;

    s.u = u[OUT_W-1:0];
    s.v = v[OUT_W-1:0];
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // The receiver stalls in stretches of random length, each with its own
  // density, including stretches where it never stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(1, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  sample_stall <= 1'b0;
      STALL_LIGHT: sample_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  sample_stall <= ($urandom_range(0, 1) == 0);
      default:     sample_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Every accepted sample transaction is matched with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected transaction, range_idx", range_idx, '0);
      end else begin
        oldest_sample = pending_samples.pop_front();
        if (range_idx !== oldest_sample.u) begin
          report_mismatch("range_idx", range_idx, oldest_sample.u);
        end
        if (azimuth_idx !== oldest_sample.v) begin
          report_mismatch("azimuth_idx", azimuth_idx, oldest_sample.v);
        end
      end
    end
  end

  // Offers one pixel and waits for its transaction. Valid is left high, so
  // the next pixel can follow on the very next cycle.
  task automatic send_pixel(input logic [ROW_W-1:0] r, input logic [ROW_W-1:0] q,
                            input logic fixed, input p2c_sample_t typed);
    coord_valid <= 1'b1;
    row <= r;
    col <= q;
    @(posedge clk);
    while (coord_stall) @(posedge clk);
    if (fixed) pending_samples.push_back(typed);
    else pending_samples.push_back(predict_sample(live_regs, r, q));
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      coord_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stops offering pixels until every predicted sample has come back.
  task automatic drain_samples();
    coord_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_HALF_EXTENT:      live_regs.half_extent = data;
      REG_CART_STEP:        live_regs.cart_step = data;
      REG_HALF_BIN:         live_regs.half_bin = data[15:0];
      REG_INV_RANGE_BIN:    live_regs.inv_range_bin = data;
      REG_FIRST_AZIMUTH:    live_regs.first_azimuth = data[18:0];
      REG_INV_AZIMUTH_STEP: live_regs.inv_azimuth_step = data;
      default: ;
    endcase
  endtask

  // Loads a full register set while the pipeline is empty. The narrow
  // registers get random junk above their width, which must be dropped, and
  // the two unused indexes get a random write each, which must change nothing.
  task automatic load_regs(input p2c_cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(NO_REG_LO, junk[23:0]);
    write_reg(REG_HALF_EXTENT, c.half_extent);
    write_reg(REG_CART_STEP, c.cart_step);
    write_reg(REG_HALF_BIN, {junk[31:24], c.half_bin});
    write_reg(REG_INV_RANGE_BIN, c.inv_range_bin);
    write_reg(REG_FIRST_AZIMUTH, {junk[28:24], c.first_azimuth});
    write_reg(REG_INV_AZIMUTH_STEP, c.inv_azimuth_step);
    junk = $urandom;
    write_reg(NO_REG_HI, junk[23:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Grid edges and the reset origin line come up often; the rest is uniform.
  function automatic logic [ROW_W-1:0] pick_coord();
    logic [ROW_W-1:0] p;
    case ($urandom_range(0, 7))
      0:       p = '0;
      1:       p = '1;
      2:       p = 9'd200;
      default: p = ROW_W'($urandom_range(0, GRID - 1));
    endcase
    return p;
  endfunction

  // Random pixels in bursts of random length with random gaps between them.
  task automatic run_random(input int count);
    int burst;
    int k;
    logic [ROW_W-1:0] r;
    logic [ROW_W-1:0] q;
    burst = $urandom_range(1, 32);
    for (k = 0; k < count; k++) begin
      if (burst == 0) begin
        hold_off($urandom_range(0, 6));
        burst = $urandom_range(1, 32);
      end
      r = pick_coord();
      q = pick_coord();
      send_pixel(r, q, 1'b0, '0);
      burst--;
    end
  endtask

  task automatic run_phase(input p2c_cfg_t c, input int count);
    drain_samples();
    load_regs(c);
    run_random(count);
  endtask

  initial begin
    p2c_cfg_t regs_at_reset;
    p2c_cfg_t phase_regs;
    p2c_sample_t typed;
    int k;

    regs_at_reset.half_extent = 24'd3276800;
    regs_at_reset.cart_step = 24'd16384;
    regs_at_reset.half_bin = 16'd1416;
    regs_at_reset.inv_range_bin = 24'd1517037;
    regs_at_reset.first_azimuth = 19'd0;
    regs_at_reset.inv_azimuth_step = 24'd4172151;
    live_regs = regs_at_reset;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels with the registers as reset left them, back to back.
    for (k = 0; k < N_DIRECTED; k++) begin
      typed.u = directed_pixels[k].u;
      typed.v = directed_pixels[k].v;
      send_pixel(directed_pixels[k].row, directed_pixels[k].col,
                 directed_pixels[k].fixed, typed);
    end

    // Random pixels on the reset registers, with one full pause in the middle.
    run_random(50);
    drain_samples();
    run_random(50);

    // Every register at the top of its field: coordinates clamp and the
    // range index saturates.
    phase_regs.half_extent = '1;
    phase_regs.cart_step = '1;
    phase_regs.half_bin = '1;
    phase_regs.inv_range_bin = '1;
    phase_regs.first_azimuth = '1;
    phase_regs.inv_azimuth_step = '1;
    run_phase(phase_regs, 75);

    // Every register at zero: all pixels collapse onto the origin.
    phase_regs = '0;
    run_phase(phase_regs, 75);

    // A tiny grid inside one range bin, so the range index is clipped at zero.
    phase_regs.half_extent = 24'd16384;
    phase_regs.cart_step = 24'd64;
    phase_regs.half_bin = 16'hFFFF;
    phase_regs.inv_range_bin = 24'($urandom);
    phase_regs.first_azimuth = 19'($urandom);
    phase_regs.inv_azimuth_step = 24'($urandom);
    run_phase(phase_regs, 75);

    // Two fully random register sets.
    repeat (2) begin
      phase_regs.half_extent = 24'($urandom);
      phase_regs.cart_step = 24'($urandom);
      phase_regs.half_bin = 16'($urandom);
      phase_regs.inv_range_bin = 24'($urandom);
      phase_regs.first_azimuth = 19'($urandom);
      phase_regs.inv_azimuth_step = 24'($urandom);
      run_phase(phase_regs, 75);
    end

    // Back to the usual geometry, but with the first beam at its largest
    // azimuth, so most azimuth indexes come out negative.
    phase_regs = regs_at_reset;
    phase_regs.first_azimuth = 19'd411774;
    run_phase(phase_regs, 75);

    // Let the last samples out, then watch a while for strays.
    coord_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guards against a hung handshake; a correct run ends long before this.
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
